>>> rtl/core/itr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_pkg
// Shared widths, constants, control types and the digit character map for
// the integer to radix text converter.
// ----------------------------------------------------------------------------

package itr_pkg;

  localparam int DEF_VALUE_BITS = 32;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] SIGN_RADIX  = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h57;  // 'a' minus ten
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // control from the sequencer to the digit row
  typedef struct packed {
    logic load;   // clear the row and load the operand
    logic run;    // one conversion step
    logic shift;  // move digits one place toward the top
  } itr_ctrl_t;

  typedef struct packed {
    logic               done;       // final conversion step this cycle
    logic [RADIX_W-1:0] top_digit;  // most significant digit cell
  } itr_stat_t;

  // digit value to lower-case ascii
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dd;
    dd = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d < 6'd10) begin
      return CHAR_ZERO + dd;
    end
    return CHAR_ALPHA + dd;
  endfunction

endpackage

>>> rtl/core/itr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_cell
// One digit cell: doubles its digit plus a carry in, reduces by the radix
// and registers the carry out for the next cell.
// ----------------------------------------------------------------------------

module itr_cell import itr_pkg::*; (
  input  logic               clk_i,
  input  logic               clear_i,
  input  logic               active_i,
  input  logic               shift_i,
  input  logic               carry_i,
  input  logic [RADIX_W-1:0] shift_in_i,
  input  logic [RADIX_W-1:0] radix_i,
  output logic [RADIX_W-1:0] digit_o,
  output logic               carry_o
);

  logic [RADIX_W-1:0] digit_q, digit_d;
  logic               carry_q, carry_d;
  logic [RADIX_W:0]   dbl;
  logic               ge;

  always_comb begin
    dbl     = {digit_q, carry_i};
    ge      = (dbl >= {1'b0, radix_i});
    digit_d = digit_q;
    carry_d = carry_q;
    if (clear_i) begin
      digit_d = '0;
      carry_d = 1'b0;
    end else if (active_i) begin
      if (ge) begin
        digit_d = RADIX_W'(dbl - {1'b0, radix_i});
      end else begin
        digit_d = dbl[RADIX_W-1:0];
      end
      carry_d = ge;
    end else if (shift_i) begin
      digit_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    carry_q <= carry_d;
  end

  assign digit_o = digit_q;
  assign carry_o = carry_q;

endmodule

>>> rtl/core/itr_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_digits
// Operand shift register feeding a skewed row of digit cells, one operand
// bit per cycle, with the step counter that retires each cell in turn.
// ----------------------------------------------------------------------------

module itr_digits import itr_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itr_ctrl_t             ctrl_i,
  input  logic [VALUE_BITS-1:0] operand_i,
  input  logic [RADIX_W-1:0]    radix_i,
  output itr_stat_t             stat_o
);

  localparam int NDIG  = VALUE_BITS;
  localparam int CNT_W = $clog2(2 * VALUE_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * VALUE_BITS - 2);

  logic [VALUE_BITS-1:0] sh_q, sh_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [RADIX_W-1:0]    digit [NDIG];
  logic [NDIG-2:0]       carry;

  always_comb begin
    sh_d  = sh_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      sh_d  = operand_i;
      cnt_d = '0;
    end else if (ctrl_i.run) begin
      sh_d  = {sh_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic               act;
    logic               cin;
    logic [RADIX_W-1:0] sin;

    assign act = ctrl_i.run && (cnt_q < CNT_W'(i + VALUE_BITS));

    if (i == 0) begin : g_first
      assign cin = sh_q[VALUE_BITS-1];
      assign sin = '0;
    end else begin : g_next
      assign cin = carry[i-1];
      assign sin = digit[i-1];
    end

    if (i == NDIG - 1) begin : g_top
      itr_cell u_cell (
        .clk_i      (clk_i),
        .clear_i    (ctrl_i.load),
        .active_i   (act),
        .shift_i    (ctrl_i.shift),
        .carry_i    (cin),
        .shift_in_i (sin),
        .radix_i    (radix_i),
        .digit_o    (digit[i]),
        .carry_o    ()
      );
    end else begin : g_mid
      itr_cell u_cell (
        .clk_i      (clk_i),
        .clear_i    (ctrl_i.load),
        .active_i   (act),
        .shift_i    (ctrl_i.shift),
        .carry_i    (cin),
        .shift_in_i (sin),
        .radix_i    (radix_i),
        .digit_o    (digit[i]),
        .carry_o    (carry[i])
      );
    end
  end

  assign stat_o.done      = ctrl_i.run && (cnt_q == CNT_LAST);
  assign stat_o.top_digit = digit[NDIG-1];

endmodule

>>> rtl/core/integer_to_radix_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_text
// Converts an operand to ascii text in a programmable radix, one character
// per output transfer, most significant digit first.
// ----------------------------------------------------------------------------
// usage
//   input channel: value_i and req_type_i, transfer when in_valid_i is high
//   and in_stall_o is low. radix is written with radix_we_i / radix_wdata_i
//   while the block is idle; reset value is ten.
//   output channel: out_char_o, last_o, bad_radix_o, transfer when
//   out_valid_o is high and out_stall_i is low. last_o marks the final
//   character of a value's text.
//   operation: the bit-serial cell row takes one operand bit per cycle,
//   skewed by the carry register between neighbouring cells; then the digit
//   row shifts out one skipped leading zero, or one character while the
//   receiver is not stalling, per cycle. a bad radix gives one error
//   transfer once the output register is free. a minus sign goes out first,
//   during the conversion unless the receiver stalls past it. the next input
//   is taken as soon as the last character is in the output register. a
//   stalled receiver holds the output register and pauses the character
//   shift. reset empties the output and returns to idle.
// ----------------------------------------------------------------------------

module integer_to_radix_text import itr_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  radix_we_i,
  input  logic [RADIX_W-1:0]    radix_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  req_type_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic                  last_o,
  output logic                  bad_radix_o
);

  localparam int NDIG = VALUE_BITS;
  localparam int K_W  = $clog2(NDIG);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [RADIX_W-1:0]    radix_q, radix_d;
  logic                  neg_q, neg_d;
  logic                  started_q, started_d;
  logic [K_W-1:0]        k_q, k_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  last_q, last_d;
  logic                  bad_q, bad_d;

  logic                  in_xfer;
  logic                  slot_free;
  logic                  radix_ok;
  logic                  skip;
  logic                  step;
  logic [VALUE_BITS-1:0] operand;
  itr_ctrl_t             ctrl;
  itr_stat_t             stat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign radix_ok   = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);

  always_comb begin
    radix_d = radix_q;
    if (radix_we_i) begin
      radix_d = radix_wdata_i;
    end
  end

  // magnitude for a negative signed decimal operand
  always_comb begin
    operand = value_i;
    if (req_type_i && (radix_q == SIGN_RADIX) && value_i[VALUE_BITS-1]) begin
      operand = VALUE_BITS'(~value_i + VALUE_BITS'(1));
    end
  end

  assign skip = (stat.top_digit == '0) && !started_q && (k_q != '0);
  assign step = (state_q == ST_EMIT) && !neg_q && (slot_free || skip);

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    started_d   = started_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    last_d      = last_q;
    bad_d       = bad_q;
    ctrl        = '0;

    if (slot_free) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!radix_ok) begin
            state_d = ST_ERR;
          end else begin
            state_d   = ST_CONV;
            ctrl.load = 1'b1;
            neg_d     = req_type_i && (radix_q == SIGN_RADIX) && value_i[VALUE_BITS-1];
            started_d = 1'b0;
          end
        end
      end
      ST_CONV: begin
        ctrl.run = 1'b1;
        if (stat.done) begin
          state_d = ST_EMIT;
          k_d     = K_W'(NDIG - 1);
        end
      end
      ST_EMIT: begin
        if (step) begin
          ctrl.shift = 1'b1;
          k_d        = k_q - K_W'(1);
          if (!skip) begin
            started_d   = 1'b1;
            out_valid_d = 1'b1;
            out_char_d  = digit_char(stat.top_digit);
            last_d      = (k_q == '0);
            bad_d       = 1'b0;
          end
          if (k_q == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_NONE;
          last_d      = 1'b1;
          bad_d       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // minus sign goes ahead of every digit
    if (neg_q && slot_free && ((state_q == ST_CONV) || (state_q == ST_EMIT))) begin
      neg_d       = 1'b0;
      out_valid_d = 1'b1;
      out_char_d  = CHAR_MINUS;
      last_d      = 1'b0;
      bad_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radix_q     <= RADIX_RESET;
      neg_q       <= 1'b0;
      started_q   <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      neg_q       <= neg_d;
      started_q   <= started_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    last_q     <= last_d;
    bad_q      <= bad_d;
  end

  itr_digits #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digits (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .operand_i (operand),
    .radix_i   (radix_q),
    .stat_o    (stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;
  assign bad_radix_o = bad_q;

`ifndef SYNTH
  a_bad_goes_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !radix_ok |=> state_q == ST_ERR)
    else $error("bad radix did not enter error state");

  a_conv_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV && stat.done |=> state_q == ST_EMIT && k_q == K_W'(NDIG - 1))
    else $error("conversion end did not start emission at top digit");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_char_q == CHAR_MINUS |-> !last_q && !bad_q)
    else $error("minus sign flagged as last or error");

  a_idle_no_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !neg_q)
    else $error("minus sign still pending at idle");

  a_err_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && bad_q |-> last_q && out_char_q == CHAR_NONE)
    else $error("error transfer malformed");
`endif

endmodule

>>> dv/integer_to_radix_text_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_text_test
// Self-checking bench for the radix text converter. A directed table covers
// the operand extremes, the minus sign, signed operands in other radixes and
// unsupported radixes. Random phases then run under several radix settings
// with bursty input and a stalling receiver. Every output transfer is checked
// field by field against table text, an error mark or a local text predictor.
// ----------------------------------------------------------------------------

module integer_to_radix_text_test;
  import itr_pkg::*;

  localparam int VALUE_W        = DEF_VALUE_BITS;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_SLACK      = 200;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
    logic              bad;
  } text_char_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TEXT, ROW_ERROR} row_kind_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  typedef struct {
    logic [RADIX_W-1:0] radix;
    logic [VALUE_W-1:0] value;
    logic               sgn;
    row_kind_e          kind;
    string              txt;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 radix_we_i;
  logic [RADIX_W-1:0]   radix_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [VALUE_W-1:0]   value_i;
  logic                 req_type_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CHAR_W-1:0]    out_char_o;
  logic                 last_o;
  logic                 bad_radix_o;

  string              digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
  text_char_t         expected_text[$];
  logic [RADIX_W-1:0] radix_now;
  int                 burst_left;
  int                 conversions;
  int                 chars_checked;
  int                 error_chars;
  int                 minus_chars;
  int                 radix_writes;
  int                 fail_count;
  int                 idle_cycles;
  bit                 hold_off_req;
  int                 hold_left;
  int                 mode_left;
  stall_mode_e        stall_mode;

  stim_row_t directed_rows[24] = '{
    '{6'd10, 32'h0000_0000, 1'b0, ROW_TEXT,    "0"},
    '{6'd10, 32'hffff_ffff, 1'b0, ROW_TEXT,    "4294967295"},
    '{6'd10, 32'hffff_ffff, 1'b1, ROW_TEXT,    "-1"},
    '{6'd10, 32'h8000_0000, 1'b1, ROW_TEXT,    "-2147483648"},
    '{6'd10, 32'h7fff_ffff, 1'b1, ROW_TEXT,    "2147483647"},
    '{6'd10, 32'h0000_0000, 1'b1, ROW_TEXT,    "0"},
    '{6'd10, 32'hffff_cfc7, 1'b1, ROW_PREDICT, ""},
    '{6'd2,  32'hffff_ffff, 1'b0, ROW_PREDICT, ""},
    '{6'd2,  32'h0000_0000, 1'b0, ROW_TEXT,    "0"},
    '{6'd2,  32'h8000_0000, 1'b1, ROW_PREDICT, ""},
    '{6'd2,  32'h0000_0001, 1'b1, ROW_TEXT,    "1"},
    '{6'd36, 32'hffff_ffff, 1'b0, ROW_TEXT,    "1z141z3"},
    '{6'd36, 32'h0000_0023, 1'b0, ROW_TEXT,    "z"},
    '{6'd36, 32'h0000_0024, 1'b1, ROW_TEXT,    "10"},
    '{6'd16, 32'hdead_beef, 1'b1, ROW_TEXT,    "deadbeef"},
    '{6'd16, 32'h8000_0000, 1'b1, ROW_TEXT,    "80000000"},
    '{6'd8,  32'hffff_ffff, 1'b0, ROW_TEXT,    "37777777777"},
    '{6'd3,  32'hffff_ffff, 1'b0, ROW_PREDICT, ""},
    '{6'd0,  32'h0000_0005, 1'b0, ROW_ERROR,   ""},
    '{6'd1,  32'hffff_ffff, 1'b1, ROW_ERROR,   ""},
    '{6'd37, 32'h1234_5678, 1'b0, ROW_ERROR,   ""},
    '{6'd63, 32'h8000_0000, 1'b1, ROW_ERROR,   ""},
    '{6'd9,  32'hffff_fff6, 1'b1, ROW_PREDICT, ""},
    '{6'd11, 32'h8000_0001, 1'b1, ROW_PREDICT, ""}
  };

  // radix per random phase, -1 picks a supported radix at random
  int phase_plan[9] = '{10, 2, 36, -1, 16, 0, -1, 63, 10};

  integer_to_radix_text #(
    .VALUE_BITS(VALUE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_we_i   (radix_we_i),
    .radix_wdata_i(radix_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .req_type_i   (req_type_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_o       (last_o),
    .bad_radix_o  (bad_radix_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void expect_char(logic [CHAR_W-1:0] ch, logic fin, logic bad);
    text_char_t c;
    c.ch  = ch;
    c.fin = fin;
    c.bad = bad;
    expected_text.push_back(c);
  endfunction

  // text of one operand in the given radix
  function automatic void predict_text(logic [VALUE_W-1:0] v, logic sgn,
                                       logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [CHAR_W-1:0]  digits[$];
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      expect_char(CHAR_NONE, 1'b1, 1'b1);
      return;
    end
    base = VALUE_W'(r);
    mag  = v;
    if (sgn && r == SIGN_RADIX && v[VALUE_W-1]) begin
      expect_char(CHAR_MINUS, 1'b0, 1'b0);
      mag = -v;
    end
    do begin
      digits.push_front(digit_set[int'(mag % base)]);
      mag = mag / base;
    end while (mag != 0);
    foreach (digits[i]) begin
      expect_char(digits[i], i == digits.size() - 1, 1'b0);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return $urandom;
    end else if (roll < 65) begin
      return $urandom >> $urandom_range(1, 31);
    end else if (roll < 80) begin
      return $urandom_range(0, 40);
    end else if (roll < 90) begin
      return -VALUE_W'($urandom_range(1, 1000));
    end
    return {1'b1, {(VALUE_W-1){1'b0}}} - VALUE_W'($urandom_range(0, 1));
  endfunction

  // offer one operand and wait for its transfer; the sender runs in bursts
  task automatic send_item(logic [VALUE_W-1:0] v, logic sgn, row_kind_e kind,
                           string txt);
    int gap;
    in_valid_i <= 1'b1;
    value_i    <= v;
    req_type_i <= sgn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    conversions++;
    case (kind)
      ROW_TEXT: begin
        for (int i = 0; i < txt.len(); i++) begin
          expect_char(txt[i], i == txt.len() - 1, 1'b0);
        end
      end
      ROW_ERROR: expect_char(CHAR_NONE, 1'b1, 1'b1);
      default: predict_text(v, sgn, radix_now);
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_radix(logic [RADIX_W-1:0] r);
    wait_idle();
    repeat (2) @(posedge clk_i);
    radix_we_i    <= 1'b1;
    radix_wdata_i <= r;
    @(posedge clk_i);
    radix_we_i <= 1'b0;
    radix_now = r;
    radix_writes++;
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = LONG_HOLD;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 2));
          mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 1) == 0);
          default:     out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin : check_output
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_checked++;
      if (bad_radix_o) error_chars++;
      if (out_char_o == CHAR_MINUS) minus_chars++;
      if (expected_text.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected transfer: char %h last %b bad %b",
                   out_char_o, last_o, bad_radix_o);
        end
      end else begin
        want = expected_text.pop_front();
        if (want.ch !== out_char_o || want.fin !== last_o || want.bad !== bad_radix_o) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at char %0d: expected %h last %b bad %b, got %h last %b bad %b",
                     chars_checked, want.ch, want.fin, want.bad,
                     out_char_o, last_o, bad_radix_o);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d characters outstanding",
                 WATCHDOG_LIMIT, expected_text.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int                 n_items;
    logic [RADIX_W-1:0] r;
    rst_ni        = 1'b0;
    radix_we_i    = 1'b0;
    radix_wdata_i = '0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    req_type_i    = 1'b0;
    out_stall_i   = 1'b0;
    radix_now     = RADIX_RESET;
    burst_left    = 0;
    hold_off_req  = 1'b0;
    hold_left     = 0;
    mode_left     = 0;
    stall_mode    = STALL_NONE;
    idle_cycles   = 0;
    conversions   = 0;
    chars_checked = 0;
    error_chars   = 0;
    minus_chars   = 0;
    radix_writes  = 0;
    fail_count    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].radix != radix_now) set_radix(directed_rows[i].radix);
      send_item(directed_rows[i].value, directed_rows[i].sgn, directed_rows[i].kind,
                directed_rows[i].txt);
    end

    foreach (phase_plan[p]) begin
      r = (phase_plan[p] < 0) ? RADIX_W'($urandom_range(2, 36)) : RADIX_W'(phase_plan[p]);
      set_radix(r);
      n_items = (r < RADIX_MIN || r > RADIX_MAX) ? 8 : 20;
      // long receiver hold-off while the sender keeps offering
      if (p == 1) hold_off_req = 1'b1;
      repeat (n_items) begin
        send_item(pick_value(), 1'($urandom_range(0, 1)), ROW_PREDICT, "");
      end
    end

    wait_idle();
    repeat (END_SLACK) @(posedge clk_i);
    $display("converted %0d operands into %0d characters across %0d radix writes",
             conversions, chars_checked, radix_writes);
    $display("saw %0d bad radix results, %0d minus signs, %0d failures",
             error_chars, minus_chars, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
